FILE: rtl/dvc_pkg.sv
package dvc_pkg;

  // table capacity and derived widths
  localparam int SET_SIZE = 16;
  localparam int IDX_W    = $clog2(SET_SIZE);
  localparam int CNT_W    = $clog2(SET_SIZE + 1);

  // field widths fixed by the interface
  localparam int VAL_W = 32;
  localparam int OCC_W = 5;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // classified request as it travels through the queue
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    drop;
  } item_t;

  typedef enum logic {
    BK_LOAD,
    BK_SCAN
  } bk_state_t;

endpackage

FILE: rtl/dvc_front.sv
module dvc_front import dvc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last_item,
  input  logic                    q_full,
  output logic                    q_push,
  output item_t                   q_item
);

  logic [CNT_W-1:0] taken_r;
  logic [CNT_W-1:0] taken_nxt;
  logic             drop;

  // a request beyond capacity is marked for dropping
  assign drop     = (taken_r >= CNT_W'(SET_SIZE));
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.value = in_value;
    q_item.last  = in_last_item;
    q_item.drop  = drop;
  end

  // count of requests taken in the current set
  always_comb begin
    taken_nxt = taken_r;
    if (q_push) begin
      if (in_last_item) begin
        taken_nxt = '0;
      end else if (!drop) begin
        taken_nxt = taken_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= '0;
    end else begin
      taken_r <= taken_nxt;
    end
  end

endmodule

FILE: rtl/dvc_queue.sv
module dvc_queue import dvc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  not_empty,
  output item_t head
);

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] fill_r;

  assign full      = (fill_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (fill_r != '0);
  assign head      = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        fill_r <= fill_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        fill_r <= fill_r - Q_CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/dvc_back.sv
module dvc_back import dvc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_not_empty,
  input  item_t                   q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_dup_value,
  output logic [OCC_W-1:0]        out_occurrences,
  output logic                    out_all_distinct,
  output logic                    out_overflow,
  output logic                    out_last_result
);

  bk_state_t state_r, state_nxt;

  // distinct value table, only entries below used_r are meaningful
  logic signed [VAL_W-1:0] vals_r   [SET_SIZE];
  logic [CNT_W-1:0]        counts_r [SET_SIZE];

  logic [CNT_W-1:0] used_r, used_nxt;
  logic             dropped_r, dropped_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // output register
  logic                    ov_r, ov_nxt;
  logic signed [VAL_W-1:0] ovalue_r, ovalue_nxt;
  logic [CNT_W-1:0]        ocnt_r, ocnt_nxt;
  logic                    odist_r, odist_nxt;
  logic                    oovf_r, oovf_nxt;
  logic                    olast_r, olast_nxt;

  logic [SET_SIZE-1:0] match;
  logic [SET_SIZE-1:0] dup_mask;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic                more_after;
  logic                slot_free;
  logic                wr_new;
  logic                wr_inc;

  // parallel compare against every stored entry
  always_comb begin
    match   = '0;
    hit_idx = '0;
    for (int k = 0; k < SET_SIZE; k++) begin
      match[k] = (CNT_W'(k) < used_r) && (vals_r[k] == q_head.value);
      if (match[k]) begin
        hit_idx = hit_idx | IDX_W'(k);
      end
    end
    hit = |match;
  end

  // entries seen more than once, and whether any lie past the scan index
  always_comb begin
    dup_mask   = '0;
    more_after = 1'b0;
    for (int k = 0; k < SET_SIZE; k++) begin
      dup_mask[k] = (CNT_W'(k) < used_r) && (counts_r[k] > CNT_W'(1));
      if (dup_mask[k] && (IDX_W'(k) > idx_r)) begin
        more_after = 1'b1;
      end
    end
  end

  assign slot_free = !ov_r || out_ready;

  // load and report sequencing
  always_comb begin
    state_nxt   = state_r;
    used_nxt    = used_r;
    dropped_nxt = dropped_r;
    idx_nxt     = idx_r;
    ov_nxt      = ov_r && !out_ready;
    ovalue_nxt  = ovalue_r;
    ocnt_nxt    = ocnt_r;
    odist_nxt   = odist_r;
    oovf_nxt    = oovf_r;
    olast_nxt   = olast_r;
    q_pop       = 1'b0;
    wr_new      = 1'b0;
    wr_inc      = 1'b0;
    case (state_r)
      BK_LOAD: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          if (q_head.drop) begin
            dropped_nxt = 1'b1;
          end else if (hit) begin
            wr_inc = 1'b1;
          end else begin
            wr_new   = 1'b1;
            used_nxt = used_r + CNT_W'(1);
          end
          if (q_head.last) begin
            state_nxt = BK_SCAN;
            idx_nxt   = '0;
          end
        end
      end
      BK_SCAN: begin
        if (dup_mask == '0) begin
          // no repeats: a single all-distinct result
          if (slot_free) begin
            ov_nxt      = 1'b1;
            ovalue_nxt  = '0;
            ocnt_nxt    = '0;
            odist_nxt   = 1'b1;
            oovf_nxt    = dropped_r;
            olast_nxt   = 1'b1;
            state_nxt   = BK_LOAD;
            used_nxt    = '0;
            dropped_nxt = 1'b0;
          end
        end else if (!dup_mask[idx_r]) begin
          idx_nxt = idx_r + IDX_W'(1);
        end else if (slot_free) begin
          ov_nxt     = 1'b1;
          ovalue_nxt = vals_r[idx_r];
          ocnt_nxt   = counts_r[idx_r];
          odist_nxt  = 1'b0;
          oovf_nxt   = dropped_r;
          olast_nxt  = !more_after;
          idx_nxt    = idx_r + IDX_W'(1);
          if (!more_after) begin
            state_nxt   = BK_LOAD;
            used_nxt    = '0;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = BK_LOAD;
      end
    endcase
  end

  // table writes
  always_ff @(posedge clk) begin
    if (wr_inc) begin
      counts_r[hit_idx] <= counts_r[hit_idx] + CNT_W'(1);
    end
    if (wr_new) begin
      vals_r[used_r[IDX_W-1:0]]   <= q_head.value;
      counts_r[used_r[IDX_W-1:0]] <= CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_LOAD;
      used_r    <= '0;
      dropped_r <= 1'b0;
      idx_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      dropped_r <= dropped_nxt;
      idx_r     <= idx_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    ovalue_r <= ovalue_nxt;
    ocnt_r   <= ocnt_nxt;
    odist_r  <= odist_nxt;
    oovf_r   <= oovf_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid        = ov_r;
  assign out_dup_value    = ovalue_r;
  assign out_occurrences  = OCC_W'(ocnt_r);
  assign out_all_distinct = odist_r;
  assign out_overflow     = oovf_r;
  assign out_last_result  = olast_r;

endmodule

FILE: rtl/duplicate_value_counter.sv
// Duplicate value counter. Requests carry one signed 32-bit value each, the
// final one of a set marked by in_last_item. Up to SET_SIZE (16) values per
// set are kept; further values are dropped and every result of that set's
// report carries out_overflow. After the final value the block reports each
// value seen more than once, in order of first appearance, with its count;
// if nothing repeats it gives one result with out_all_distinct set. The last
// result of a report has out_last_result set. Values are loaded at one per
// cycle: a front end tags each request and passes it through a four-entry
// queue to the table, which compares against all stored entries at once.
// The report walks the table one entry per cycle up to the last repeated
// entry, a result being registered in the cycle its entry is visited; it
// pauses on a repeated entry while the output register is still held by
// the receiver. Requests of the next set are queued meanwhile, until the
// queue fills.
module duplicate_value_counter import dvc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_dup_value,
  output logic [OCC_W-1:0]        out_occurrences,
  output logic                    out_all_distinct,
  output logic                    out_overflow,
  output logic                    out_last_result
);

  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_not_empty;
  item_t q_in;
  item_t q_head;

  // request tagging
  dvc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .in_last_item (in_last_item),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in)
  );

  // decoupling queue
  dvc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // table and report
  dvc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dup_value    (out_dup_value),
    .out_occurrences  (out_occurrences),
    .out_all_distinct (out_all_distinct),
    .out_overflow     (out_overflow),
    .out_last_result  (out_last_result)
  );

endmodule
